// ----- rtl/ber_tlv_header_parser_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BER_TLV_HEADER_PARSER_DEFINES_SVH
`define BER_TLV_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, masked while aresetn is low
`define BTHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while aresetn is low
`define BTHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bthp_pkg.sv -----
`timescale 1ns / 1ps

package bthp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_IDENT   = 3'd0,
        PH_TAGHI   = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LENLONG = 3'd3,
        PH_CONTENT = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_CONTENT = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EARLY_END  = 3'd1,
        ST_TAG_OVF    = 3'd2,
        ST_LEN_OVF    = 3'd3,
        ST_INDEFINITE = 3'd4,
        ST_SHORT      = 3'd5
    } status_t;

    // Identifier octet fields
    localparam logic [4:0]  TAG_HIGH_FORM = 5'h1F;
    // Largest accumulators that still take one more shift within 32 bits (tag) or 31 bits (length)
    localparam logic [31:0] TAG_LIMIT     = 32'h01FF_FFFF;
    localparam logic [31:0] LEN_LIMIT     = 32'h007F_FFFF;

    // Bus widths in bits
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TDATA_W = 80;

    // One result beat
    typedef struct packed {
        status_t     status;
        logic        last_content;
        logic [7:0]  content_byte;
        logic [31:0] content_length;
        logic [31:0] tag_number;
        logic        is_constructed;
        logic [1:0]  tag_class;
        kind_t       kind;
    } result_t;

endpackage

// ----- rtl/ber_tlv_header_parser.sv -----
`timescale 1ns / 1ps

// BER tag-length header parser. Takes one byte of an encoded buffer per beat
// (s_tlast on the buffer's last byte) and emits at most one result beat per
// input beat: a header when the identifier and definite length are complete,
// each content byte of a primitive element, or an error report, after which
// bytes are dropped up to the buffer end. Constructed content is parsed again
// as headers. One byte is taken every cycle unless the output buffer is full;
// each result is registered in the output buffer before it is shown. The rate
// is set by the update of the parse state on each byte, and the two-entry
// output buffer keeps s_tready free of any combinational path from m_tready.
module ber_tlv_header_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bthp_pkg::DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                         s_tlast,   // buffer_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] tag_class, [2] is_constructed, [34:3] tag_number,
    // [66:35] content_length, [74:67] content_byte, [77:75] status, [79:78] zero
    output logic [bthp_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] kind
    output logic                         m_tlast    // last_content
);
    import bthp_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    bthp_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .data_byte  (s_tdata),
        .buffer_end (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    bthp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack result fields onto the stream
    assign m_tdata = {2'b00, out_res.status, out_res.content_byte,
                      out_res.content_length, out_res.tag_number,
                      out_res.is_constructed, out_res.tag_class};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_content;

endmodule

// ----- rtl/bthp_engine.sv -----
`timescale 1ns / 1ps

module bthp_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                buffer_end,
    output logic                res_valid,
    output bthp_pkg::result_t   res
);
    import bthp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [31:0] tag_reg,    tag_next;
    logic [31:0] len_reg,    len_next;
    logic [6:0]  left_reg,   left_next;
    logic [31:0] rem_reg,    rem_next;
    logic [1:0]  class_reg,  class_next;
    logic        constr_reg, constr_next;

    logic        do_err;
    status_t     err_code;
    logic        do_hdr;
    logic [31:0] hdr_len;
    logic [31:0] rem_dec;
    logic [6:0]  left_dec;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDENT;
            tag_reg    <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            rem_reg    <= '0;
            class_reg  <= '0;
            constr_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            left_reg   <= left_next;
            rem_reg    <= rem_next;
            class_reg  <= class_next;
            constr_reg <= constr_next;
        end
    end

    assign rem_dec  = rem_reg - 32'd1;
    assign left_dec = left_reg - 7'd1;

    // Per-byte parse step
    always_comb begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        rem_next    = rem_reg;
        class_next  = class_reg;
        constr_next = constr_reg;
        do_err      = 1'b0;
        err_code    = ST_OK;
        do_hdr      = 1'b0;
        hdr_len     = len_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (in_fire) begin
            case (phase_reg)
                PH_TAGHI: begin
                    if (tag_reg > TAG_LIMIT) begin
                        do_err   = 1'b1;
                        err_code = ST_TAG_OVF;
                    end else begin
                        tag_next = {tag_reg[24:0], data_byte[6:0]};
                        if (buffer_end) begin
                            do_err   = 1'b1;
                            err_code = ST_EARLY_END;
                        end else if (!data_byte[7]) begin
                            phase_next = PH_LEN1;
                        end
                    end
                end
                PH_LEN1: begin
                    if (data_byte[7]) begin
                        if (data_byte[6:0] == 7'd0) begin
                            do_err   = 1'b1;
                            err_code = ST_INDEFINITE;
                        end else begin
                            len_next  = '0;
                            left_next = data_byte[6:0];
                            if (buffer_end) begin
                                do_err   = 1'b1;
                                err_code = ST_EARLY_END;
                            end else begin
                                phase_next = PH_LENLONG;
                            end
                        end
                    end else begin
                        len_next = {24'd0, data_byte};
                        hdr_len  = {24'd0, data_byte};
                        do_hdr   = 1'b1;
                    end
                end
                PH_LENLONG: begin
                    if (len_reg > LEN_LIMIT) begin
                        do_err   = 1'b1;
                        err_code = ST_LEN_OVF;
                    end else begin
                        len_next  = {len_reg[23:0], data_byte};
                        hdr_len   = {len_reg[23:0], data_byte};
                        left_next = left_dec;
                        if (left_dec == 7'd0) begin
                            do_hdr = 1'b1;
                        end else if (buffer_end) begin
                            do_err   = 1'b1;
                            err_code = ST_EARLY_END;
                        end
                    end
                end
                PH_CONTENT: begin
                    rem_next = rem_dec;
                    if (buffer_end && (rem_dec != 32'd0)) begin
                        do_err   = 1'b1;
                        err_code = ST_SHORT;
                    end else begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_CONTENT;
                        res.content_byte = data_byte;
                        if (rem_dec == 32'd0) begin
                            res.last_content = 1'b1;
                            phase_next       = PH_IDENT;
                        end
                    end
                end
                PH_DISCARD: begin
                    if (buffer_end) begin
                        phase_next = PH_IDENT;
                    end
                end
                default: begin
                    // identifier octet
                    class_next  = data_byte[7:6];
                    constr_next = data_byte[5];
                    tag_next    = {27'd0, data_byte[4:0]};
                    len_next    = '0;
                    left_next   = '0;
                    rem_next    = '0;
                    if (buffer_end) begin
                        do_err   = 1'b1;
                        err_code = ST_EARLY_END;
                    end else if (data_byte[4:0] == TAG_HIGH_FORM) begin
                        tag_next   = '0;
                        phase_next = PH_TAGHI;
                    end else begin
                        phase_next = PH_LEN1;
                    end
                end
            endcase

            // header complete, unless the buffer ends with content owed
            if (do_hdr) begin
                if (buffer_end && (hdr_len != 32'd0)) begin
                    do_err   = 1'b1;
                    err_code = ST_SHORT;
                end else begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_HEADER;
                    res.tag_class      = class_reg;
                    res.is_constructed = constr_reg;
                    res.tag_number     = tag_reg;
                    res.content_length = hdr_len;
                    if (!constr_reg && (hdr_len != 32'd0)) begin
                        rem_next   = hdr_len;
                        phase_next = PH_CONTENT;
                    end else begin
                        phase_next = PH_IDENT;
                    end
                end
            end

            // error report replaces anything else of this beat
            if (do_err) begin
                res_valid  = 1'b1;
                res        = '0;
                res.kind   = KIND_ERROR;
                res.status = err_code;
                phase_next = buffer_end ? PH_IDENT : PH_DISCARD;
            end
        end
    end

endmodule

// ----- rtl/bthp_out_stage.sv -----
`timescale 1ns / 1ps

module bthp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    input  bthp_pkg::result_t   res,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output bthp_pkg::result_t   out_res
);
    import bthp_pkg::*;

    logic    main_valid_reg, main_valid_next;
    result_t main_reg,       main_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg,       skid_next;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // Skid buffer: input side only sees the skid slot, never out_ready
    always_comb begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (main_valid_reg && !out_ready) begin
            // output stalled: park a new result in the skid slot
            if (res_valid) begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end else if (skid_valid_reg) begin
            main_valid_next = 1'b1;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end else begin
            main_valid_next = res_valid;
            main_next       = res;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

// ----- rtl/bthp_checker.sv -----
`timescale 1ns / 1ps
`include "ber_tlv_header_parser_defines.svh"

module bthp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [bthp_pkg::DATA_W-1:0]  s_tdata,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bthp_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);
    import bthp_pkg::*;

    // Stalled result beat holds
    `BTHP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")

    // No result appears without an accepted byte or a pending one
    `BTHP_ASSERT_NEXT(a_no_invent, !(s_tvalid && s_tready) && !m_tvalid, !m_tvalid, "result beat without input")

    // Content beat carries only the byte and last mark
    `BTHP_ASSERT_NOW(a_content_clean, m_tvalid && (m_tuser == KIND_CONTENT), m_tdata[66:0] == '0 && m_tdata[79:75] == '0, "content beat has stray fields")

    // Error beat carries a nonzero status and nothing else
    `BTHP_ASSERT_NOW(a_error_clean, m_tvalid && (m_tuser == KIND_ERROR), m_tdata[77:75] != ST_OK && m_tdata[74:0] == '0 && !m_tlast, "malformed error beat")

    // Only the three result kinds are ever shown
    `BTHP_ASSERT_NOW(a_kind_valid, m_tvalid, m_tuser == KIND_HEADER || m_tuser == KIND_CONTENT || m_tuser == KIND_ERROR, "unknown result kind")

endmodule

bind ber_tlv_header_parser bthp_checker u_bthp_checker (.*);

// ----- tb/ber_tlv_header_parser_test.sv -----
`timescale 1ns / 1ps

module ber_tlv_header_parser_test;
    import bthp_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int STALL_CYCLES = 80;

    typedef struct {
        logic [7:0] data;
        logic       eob;
        logic       pinned;   // expectation typed into the table
        result_t    want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [7:0] data_byte
    logic                s_tlast;   // buffer_end
    logic                m_tvalid;
    logic                m_tready;
    // [1:0] tag_class, [2] is_constructed, [34:3] tag_number,
    // [66:35] content_length, [74:67] content_byte, [77:75] status, [79:78] zero
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;   // [1:0] kind
    logic                m_tlast;   // last_content

    // Table expectation travels alongside the beat
    logic                row_pinned;
    result_t             row_want;

    ber_tlv_header_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Scoreboard state and run statistics
    result_t    pending_results[$];
    stim_row_t  directed_rows[$];
    stim_row_t  burst[$];
    int         mismatches = 0;
    int         parsed_items = 0;
    int         header_count = 0;
    int         content_count = 0;
    int         status_count[8];
    int         backpressure_cycles = 0;
    bit         stall_done = 1'b0;
    bit         long_len_done = 1'b0;
    logic       steady;

    // No idling on either side through this window
    assign steady = (parsed_items >= 900) && (parsed_items < 1200);

    // Parser mirror
    phase_t      prs_phase;
    logic [31:0] prs_tag;
    logic [31:0] prs_len;
    logic [31:0] prs_remain;
    logic [6:0]  prs_octets;
    logic [1:0]  prs_class;
    logic        prs_cons;

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic result_t hdr_exp(input logic [1:0] cls, input logic cons,
                                        input logic [31:0] tag, input logic [31:0] len);
        result_t r;
        r                = '0;
        r.kind           = KIND_HEADER;
        r.tag_class      = cls;
        r.is_constructed = cons;
        r.tag_number     = tag;
        r.content_length = len;
        return r;
    endfunction

    function automatic result_t err_exp(input status_t st);
        result_t r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = st;
        return r;
    endfunction

    // Error report; drop bytes up to buffer end unless this one is it
    task automatic abort_parse(input status_t st, input logic eob,
                               output bit emits, output result_t res);
        emits     = 1'b1;
        res       = err_exp(st);
        prs_phase = eob ? PH_IDENT : PH_DISCARD;
    endtask

    task automatic close_header(input logic eob, output bit emits, output result_t res);
        if (eob && prs_len != 0) begin
            abort_parse(ST_SHORT, eob, emits, res);
        end else begin
            emits = 1'b1;
            res   = hdr_exp(prs_class, prs_cons, prs_tag, prs_len);
            if (!prs_cons && prs_len != 0) begin
                prs_remain = prs_len;
                prs_phase  = PH_CONTENT;
            end else begin
                prs_phase = PH_IDENT;
            end
        end
    endtask

    // One accepted byte through the parser mirror
    task automatic decode_byte(input logic [7:0] b, input logic eob,
                               output bit emits, output result_t res);
        emits = 1'b0;
        res   = '0;
        case (prs_phase)
            PH_TAGHI: begin
                if (prs_tag > TAG_LIMIT) begin
                    abort_parse(ST_TAG_OVF, eob, emits, res);
                end else begin
                    prs_tag = {prs_tag[24:0], b[6:0]};
                    if (eob)
                        abort_parse(ST_EARLY_END, eob, emits, res);
                    else if (!b[7])
                        prs_phase = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if (b[7]) begin
                    if (b[6:0] == 7'd0) begin
                        abort_parse(ST_INDEFINITE, eob, emits, res);
                    end else begin
                        prs_len    = '0;
                        prs_octets = b[6:0];
                        if (eob)
                            abort_parse(ST_EARLY_END, eob, emits, res);
                        else
                            prs_phase = PH_LENLONG;
                    end
                end else begin
                    prs_len = {24'd0, b};
                    close_header(eob, emits, res);
                end
            end
            PH_LENLONG: begin
                if (prs_len > LEN_LIMIT) begin
                    abort_parse(ST_LEN_OVF, eob, emits, res);
                end else begin
                    prs_len    = {prs_len[23:0], b};
                    prs_octets = prs_octets - 7'd1;
                    if (prs_octets == 7'd0)
                        close_header(eob, emits, res);
                    else if (eob)
                        abort_parse(ST_EARLY_END, eob, emits, res);
                end
            end
            PH_CONTENT: begin
                prs_remain = prs_remain - 32'd1;
                if (eob && prs_remain != 0) begin
                    abort_parse(ST_SHORT, eob, emits, res);
                end else begin
                    emits            = 1'b1;
                    res.kind         = KIND_CONTENT;
                    res.content_byte = b;
                    if (prs_remain == 0) begin
                        res.last_content = 1'b1;
                        prs_phase        = PH_IDENT;
                    end
                end
            end
            PH_DISCARD: begin
                if (eob)
                    prs_phase = PH_IDENT;
            end
            default: begin
                prs_class  = b[7:6];
                prs_cons   = b[5];
                prs_tag    = {27'd0, b[4:0]};
                prs_len    = '0;
                prs_octets = '0;
                prs_remain = '0;
                if (eob) begin
                    abort_parse(ST_EARLY_END, eob, emits, res);
                end else if (b[4:0] == TAG_HIGH_FORM) begin
                    prs_tag   = '0;
                    prs_phase = PH_TAGHI;
                end else begin
                    prs_phase = PH_LEN1;
                end
            end
        endcase
    endtask

    // Compare one result beat against the oldest expectation
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0) begin
            note_mismatch($sformatf("result with nothing expected, kind %0d", m_tuser));
            return;
        end
        want = pending_results.pop_front();
        if (m_tuser != want.kind)
            note_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
        if (m_tdata[1:0] != want.tag_class)
            note_mismatch($sformatf("tag_class %0d, want %0d", m_tdata[1:0], want.tag_class));
        if (m_tdata[2] != want.is_constructed)
            note_mismatch($sformatf("is_constructed %0d, want %0d",
                                    m_tdata[2], want.is_constructed));
        if (m_tdata[34:3] != want.tag_number)
            note_mismatch($sformatf("tag_number %h, want %h", m_tdata[34:3], want.tag_number));
        if (m_tdata[66:35] != want.content_length)
            note_mismatch($sformatf("content_length %h, want %h",
                                    m_tdata[66:35], want.content_length));
        if (m_tdata[74:67] != want.content_byte)
            note_mismatch($sformatf("content_byte %h, want %h",
                                    m_tdata[74:67], want.content_byte));
        if (m_tlast != want.last_content)
            note_mismatch($sformatf("last_content %0d, want %0d", m_tlast, want.last_content));
        if (m_tdata[77:75] != want.status)
            note_mismatch($sformatf("status %0d, want %0d", m_tdata[77:75], want.status));
        if (m_tdata[79:78] != 2'b00)
            note_mismatch($sformatf("pad bits %b not zero", m_tdata[79:78]));
        if (want.kind == KIND_HEADER)
            header_count++;
        else if (want.kind == KIND_CONTENT)
            content_count++;
        else
            status_count[want.status]++;
    endtask

    // Both channels sampled at the rising edge
    always @(posedge aclk) begin
        bit      emits;
        result_t res;
        if (!aresetn) begin
            prs_phase  = PH_IDENT;
            prs_tag    = '0;
            prs_len    = '0;
            prs_remain = '0;
            prs_octets = '0;
            prs_class  = '0;
            prs_cons   = 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && !s_tready)
                backpressure_cycles++;
            if (s_tvalid && s_tready) begin
                parsed_items++;
                decode_byte(s_tdata, s_tlast, emits, res);
                if (row_pinned)
                    pending_results = {pending_results, row_want};
                else if (emits)
                    pending_results = {pending_results, res};
            end
        end
    end

    // Receiver: random idling, one long hold-off
    initial begin
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!stall_done && parsed_items >= 400) begin
                stall_done = 1'b1;
                hold       = STALL_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 9);
            end
        end
    end

    task automatic add_byte(input logic [7:0] d, input logic eob);
        stim_row_t r;
        r.data   = d;
        r.eob    = eob;
        r.pinned = 1'b0;
        r.want   = '0;
        directed_rows = {directed_rows, r};
    endtask

    task automatic add_pinned(input logic [7:0] d, input logic eob, input result_t want);
        stim_row_t r;
        r.data   = d;
        r.eob    = eob;
        r.pinned = 1'b1;
        r.want   = want;
        directed_rows = {directed_rows, r};
    endtask

    task automatic put_byte(input logic [7:0] d);
        stim_row_t r;
        r.data   = d;
        r.eob    = 1'b0;
        r.pinned = 1'b0;
        r.want   = '0;
        burst = {burst, r};
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input stim_row_t row);
        while (!steady && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= row.data;
        s_tlast    <= row.eob;
        row_pinned <= row.pinned;
        row_want   <= row.want;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Well-formed element: identifier, tag, length, content if primitive
    task automatic put_element();
        logic [1:0]  cls;
        logic        cons;
        logic [31:0] len;
        int          k;
        int          nbytes;
        cls  = 2'($urandom_range(3));
        cons = ($urandom_range(3) == 0);
        if ($urandom_range(3) != 0) begin
            put_byte({cls, cons, 5'($urandom_range(30))});
        end else begin
            put_byte({cls, cons, TAG_HIGH_FORM});
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
                put_byte({(i != k - 1), 7'($urandom_range(127))});
        end
        if (cons)
            len = $urandom_range(0, 20);
        else if ($urandom_range(9) == 0)
            len = $urandom_range(8, 300);
        else
            len = $urandom_range(0, 6);
        if (len < 128 && $urandom_range(2) != 0) begin
            put_byte(len[7:0]);
        end else begin
            nbytes = ((len > 255) ? 2 : 1) + $urandom_range(0, 2);
            put_byte(8'h80 | 8'(nbytes));
            for (int i = nbytes - 1; i >= 0; i--)
                put_byte(8'(len >> (8 * i)));
        end
        if (!cons)
            repeat (len) put_byte(8'($urandom_range(255)));
    endtask

    // Header with unchecked tag and length octets, then a few bytes
    task automatic put_wild_header();
        int         k;
        int         nlen;
        logic [7:0] b;
        if (!long_len_done || $urandom_range(19) == 0) begin
            // every one of the 127 length octets used, mostly leading zeros
            long_len_done = 1'b1;
            put_byte(8'h04);
            put_byte(8'hFF);
            repeat (126) put_byte(8'h00);
            put_byte(8'h02);
            put_byte(8'($urandom_range(255)));
            put_byte(8'($urandom_range(255)));
            return;
        end
        b = 8'($urandom_range(255));
        if ($urandom_range(1) == 0)
            b[4:0] = TAG_HIGH_FORM;
        put_byte(b);
        if (b[4:0] == TAG_HIGH_FORM) begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++) begin
                b = 8'($urandom_range(255));
                b[7] = (i != k - 1) || ($urandom_range(3) == 0);
                put_byte(b);
            end
        end
        nlen = $urandom_range(0, 8);
        if (nlen == 0) begin
            put_byte(($urandom_range(3) == 0) ? 8'h80 : 8'($urandom_range(255)));
        end else begin
            put_byte(8'h80 | 8'(nlen));
            repeat (nlen) begin
                case ($urandom_range(2))
                    0:       put_byte(8'h00);
                    1:       put_byte(8'hFF);
                    default: put_byte(8'($urandom_range(255)));
                endcase
            end
        end
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(255)));
    endtask

    // One encoded buffer: clean, cut short, loose header, or noise
    task automatic build_buffer();
        int mode;
        int cut;
        burst = {};
        mode  = $urandom_range(99);
        if (mode < 70) begin
            repeat ($urandom_range(1, 4)) put_element();
            if (mode >= 58) begin
                cut = $urandom_range(1, burst.size());
                while (burst.size() > cut)
                    void'(burst.pop_back());
            end
        end else if (mode < 85) begin
            put_wild_header();
        end else begin
            repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
            foreach (burst[i])
                burst[i].eob = ($urandom_range(9) == 0);
        end
        burst[burst.size() - 1].eob = 1'b1;
    endtask

    // Stimulus and end of run
    initial begin
        int drain;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        row_pinned = 1'b0;
        row_want   = '0;

        // constructed wrapper holding one primitive element
        add_byte  (8'h30, 1'b0);
        add_pinned(8'h03, 1'b0, hdr_exp(2'd0, 1'b1, 32'd16, 32'd3));
        add_byte  (8'h02, 1'b0);
        add_pinned(8'h01, 1'b0, hdr_exp(2'd0, 1'b0, 32'd2, 32'd1));
        add_byte  (8'h7F, 1'b0);
        // buffer ends on the identifier
        add_pinned(8'hFF, 1'b1, err_exp(ST_EARLY_END));
        // indefinite length, then discard through buffer end
        add_byte  (8'h30, 1'b0);
        add_pinned(8'h80, 1'b0, err_exp(ST_INDEFINITE));
        add_byte  (8'h00, 1'b1);
        // largest high-form tag, private class, zero length on the last byte
        add_byte  (8'hDF, 1'b0);
        add_byte  (8'h8F, 1'b0);
        add_byte  (8'hFF, 1'b0);
        add_byte  (8'hFF, 1'b0);
        add_byte  (8'hFF, 1'b0);
        add_byte  (8'h7F, 1'b0);
        add_pinned(8'h00, 1'b1, hdr_exp(2'd3, 1'b0, 32'hFFFF_FFFF, 32'd0));
        // long-form length past 31 bits
        add_byte  (8'h04, 1'b0);
        add_byte  (8'h84, 1'b0);
        add_byte  (8'h80, 1'b0);
        add_byte  (8'h00, 1'b0);
        add_byte  (8'h00, 1'b0);
        add_pinned(8'h00, 1'b1, err_exp(ST_LEN_OVF));
        // content cut short by buffer end
        add_byte  (8'h04, 1'b0);
        add_byte  (8'h02, 1'b0);
        add_pinned(8'hAA, 1'b1, err_exp(ST_SHORT));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);
        while (parsed_items < directed_rows.size() + RANDOM_ITEMS) begin
            build_buffer();
            foreach (burst[i])
                send_beat(burst[i]);
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (8) @(posedge aclk);
        while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            note_mismatch("expected result never arrived");
        end

        $display("run: %0d bytes in, %0d headers, %0d content bytes", parsed_items,
                 header_count, content_count);
        $display("errors early/tag/len/indef/short %0d/%0d/%0d/%0d/%0d, input held %0d cycles",
                 status_count[ST_EARLY_END], status_count[ST_TAG_OVF],
                 status_count[ST_LEN_OVF], status_count[ST_INDEFINITE],
                 status_count[ST_SHORT], backpressure_cycles);
        if (mismatches == 0)
            $display("ber_tlv_header_parser_test: clean");
        else
            $display("ber_tlv_header_parser_test: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("timeout @%0t", $time);
        $display("ber_tlv_header_parser_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/bthp_pkg.sv
rtl/bthp_engine.sv
rtl/bthp_out_stage.sv
rtl/ber_tlv_header_parser.sv
rtl/bthp_checker.sv
tb/ber_tlv_header_parser_test.sv
